// ===== hdl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared types, codes and saturation helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int unsigned FracBitsDefault   = 16;
  localparam int unsigned QueueDepthDefault = 2;

  // Operation codes as they arrive on the input channel.
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_NEG   = 3'd4;
  localparam logic [2:0] OP_CONJ  = 3'd5;
  localparam logic [2:0] OP_EQUAL = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [1:0] REG_EQUAL_TOL = 2'd0;

  // Operation class as decoded by the front end.
  typedef enum logic [2:0] {
    CLS_ADD   = 3'd0,
    CLS_SUB   = 3'd1,
    CLS_MUL   = 3'd2,
    CLS_DIV   = 3'd3,
    CLS_NEG   = 3'd4,
    CLS_CONJ  = 3'd5,
    CLS_EQUAL = 3'd6,
    CLS_NOP   = 3'd7
  } cls_e;

  typedef struct packed {
    logic        [2:0]  operation;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic               is_equal;
    logic        [1:0]  status;
  } out_t;

  typedef struct packed {
    cls_e               cls;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } item_t;

  // Signed value from sign and magnitude, saturated; returns {overflow, value}.
  function automatic logic [32:0] sat_mag(logic neg, logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(64'd0 - mag)};
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  // Saturate a 33-bit signed sum to 32 bits; returns {overflow, value}.
  function automatic logic [32:0] sat_s33(logic signed [32:0] s);
    logic [32:0] r;
    if (s[32] != s[31]) r = s[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    else r = {1'b0, s[31:0]};
    return r;
  endfunction

endpackage

// ===== hdl/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts input items, decodes the operation and hands items to the queue.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cau_pkg::in_t    in_data_i,
  output logic            push_o,
  output cau_pkg::item_t  item_o,
  input  logic            full_i
);

  logic           hold_v_q, hold_v_d;
  cau_pkg::item_t hold_q;
  cau_pkg::item_t dec;
  logic           accept;

  always_comb begin
    dec.a_real = in_data_i.a_real;
    dec.a_imag = in_data_i.a_imag;
    dec.b_real = in_data_i.b_real;
    dec.b_imag = in_data_i.b_imag;
    case (in_data_i.operation)
      cau_pkg::OP_ADD:   dec.cls = cau_pkg::CLS_ADD;
      cau_pkg::OP_SUB:   dec.cls = cau_pkg::CLS_SUB;
      cau_pkg::OP_MUL:   dec.cls = cau_pkg::CLS_MUL;
      cau_pkg::OP_DIV:   dec.cls = cau_pkg::CLS_DIV;
      cau_pkg::OP_NEG:   dec.cls = cau_pkg::CLS_NEG;
      cau_pkg::OP_CONJ:  dec.cls = cau_pkg::CLS_CONJ;
      cau_pkg::OP_EQUAL: dec.cls = cau_pkg::CLS_EQUAL;
      default:           dec.cls = cau_pkg::CLS_NOP;
    endcase
  end

  assign in_stall_o = hold_v_q && full_i;
  assign push_o     = hold_v_q && !full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = hold_q;

  always_comb begin
    hold_v_d = accept || (hold_v_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= dec;
    end
  end

endmodule

// ===== hdl/cau_fifo.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit queue
// Short first-in first-out queue between the front end and the datapath.
// ----------------------------------------------------------------------------
module cau_fifo #(
  parameter int unsigned DEPTH = cau_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cau_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output cau_pkg::item_t data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cau_pkg::item_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/cau_back.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit datapath
// Pipelined multiply, sum and restoring-divide datapath with output register.
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int unsigned FRAC_BITS = cau_pkg::FracBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [30:0]    tol_i,
  input  logic           item_valid_i,
  input  cau_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           valid_o,
  output cau_pkg::out_t  res_o,
  input  logic           stall_i
);

  localparam int unsigned DenW = 64;
  localparam int unsigned QW   = 33;
  localparam int unsigned RW   = DenW + QW;

  typedef struct packed {
    logic               is_div;
    logic               div0;
    logic               neg_re;
    logic               neg_im;
    logic               ovf_re;
    logic               ovf_im;
    logic [DenW-1:0]    den;
    logic [RW-1:0]      rem_re;
    logic [RW-1:0]      rem_im;
    logic [QW-1:0]      q_re;
    logic [QW-1:0]      q_im;
    cau_pkg::out_t      res;
  } div_t;

  logic adv;
  assign adv        = !valid_o || !stall_i;
  assign item_pop_o = adv && item_valid_i;

  // Stage A: products and the simple operations.
  logic               a_v_q;
  cau_pkg::cls_e      a_cls_q;
  logic signed [63:0] a_rr_q, a_ii_q, a_ri_q, a_ir_q;
  logic signed [63:0] a_rr_d, a_ii_d, a_ri_d, a_ir_d, sqr_full, sqi_full;
  logic [62:0]        a_sqr_q, a_sqi_q;
  cau_pkg::out_t      a_res_q, a_res_d;
  logic [32:0]        sr, si;
  logic signed [32:0] dr, di;
  logic [32:0]        mdr, mdi;

  always_comb begin
    a_rr_d   = 64'(item_i.a_real) * 64'(item_i.b_real);
    a_ii_d   = 64'(item_i.a_imag) * 64'(item_i.b_imag);
    a_ri_d   = 64'(item_i.a_real) * 64'(item_i.b_imag);
    a_ir_d   = 64'(item_i.a_imag) * 64'(item_i.b_real);
    sqr_full = 64'(item_i.b_real) * 64'(item_i.b_real);
    sqi_full = 64'(item_i.b_imag) * 64'(item_i.b_imag);
    dr  = 33'(item_i.a_real) - 33'(item_i.b_real);
    di  = 33'(item_i.a_imag) - 33'(item_i.b_imag);
    mdr = dr[32] ? 33'(-dr) : 33'(dr);
    mdi = di[32] ? 33'(-di) : 33'(di);
    sr  = '0;
    si  = '0;
    a_res_d = '0;
    case (item_i.cls)
      cau_pkg::CLS_ADD: begin
        sr = cau_pkg::sat_s33(33'(item_i.a_real) + 33'(item_i.b_real));
        si = cau_pkg::sat_s33(33'(item_i.a_imag) + 33'(item_i.b_imag));
      end
      cau_pkg::CLS_SUB: begin
        sr = cau_pkg::sat_s33(dr);
        si = cau_pkg::sat_s33(di);
      end
      cau_pkg::CLS_NEG: begin
        sr = cau_pkg::sat_s33(-33'(item_i.a_real));
        si = cau_pkg::sat_s33(-33'(item_i.a_imag));
      end
      cau_pkg::CLS_CONJ: begin
        sr = {1'b0, item_i.a_real};
        si = cau_pkg::sat_s33(-33'(item_i.a_imag));
      end
      cau_pkg::CLS_EQUAL: begin
        a_res_d.is_equal = (mdr < {2'b00, tol_i}) && (mdi < {2'b00, tol_i});
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    a_res_d.c_real = sr[31:0];
    a_res_d.c_imag = si[31:0];
    a_res_d.status = (sr[32] || si[32]) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
  end

  // Stage B: exact sums and the denominator.
  logic               b_v_q;
  cau_pkg::cls_e      b_cls_q;
  logic signed [64:0] b_sre_q, b_sim_q, b_sre_d, b_sim_d;
  logic [DenW-1:0]    b_den_q;
  cau_pkg::out_t      b_res_q;
  logic signed [64:0] xrr, xii, xri, xir;

  always_comb begin
    xrr = 65'(a_rr_q);
    xii = 65'(a_ii_q);
    xri = 65'(a_ri_q);
    xir = 65'(a_ir_q);
    if (a_cls_q == cau_pkg::CLS_DIV) begin
      b_sre_d = xrr + xii;
      b_sim_d = xir - xri;
    end else begin
      b_sre_d = xrr - xii;
      b_sim_d = xri + xir;
    end
  end

  // Stage C: sign and magnitude.
  logic            c_v_q;
  cau_pkg::cls_e   c_cls_q;
  logic            c_neg_re_q, c_neg_im_q;
  logic [63:0]     c_mag_re_q, c_mag_im_q;
  logic [DenW-1:0] c_den_q;
  cau_pkg::out_t   c_res_q;

  // Divider stages: entry zero is set up from stage C, then one quotient bit a stage.
  logic  dv_v_q [QW+1];
  div_t  dv_q   [QW+1];
  div_t  dv_d   [QW+1];
  logic [RW-1:0] num_re, num_im;
  logic [32:0]   mr, mi;

  always_comb begin
    num_re = RW'(c_mag_re_q) << FRAC_BITS;
    num_im = RW'(c_mag_im_q) << FRAC_BITS;
    mr     = cau_pkg::sat_mag(c_neg_re_q, c_mag_re_q >> FRAC_BITS);
    mi     = cau_pkg::sat_mag(c_neg_im_q, c_mag_im_q >> FRAC_BITS);
    dv_d[0].is_div = (c_cls_q == cau_pkg::CLS_DIV);
    dv_d[0].div0   = (c_den_q == '0);
    dv_d[0].neg_re = c_neg_re_q;
    dv_d[0].neg_im = c_neg_im_q;
    // A quotient of 2^33 or more saturates, whatever its low bits.
    dv_d[0].ovf_re = (num_re >> QW) >= RW'(c_den_q);
    dv_d[0].ovf_im = (num_im >> QW) >= RW'(c_den_q);
    dv_d[0].den    = c_den_q;
    dv_d[0].rem_re = num_re;
    dv_d[0].rem_im = num_im;
    dv_d[0].q_re   = '0;
    dv_d[0].q_im   = '0;
    dv_d[0].res    = c_res_q;
    case (c_cls_q)
      cau_pkg::CLS_MUL: begin
        dv_d[0].res.c_real = mr[31:0];
        dv_d[0].res.c_imag = mi[31:0];
        dv_d[0].res.status = (mr[32] || mi[32]) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
      end
      cau_pkg::CLS_DIV: begin
        dv_d[0].res        = '0;
        dv_d[0].res.status = (c_den_q == '0) ? cau_pkg::ST_DIV0 : cau_pkg::ST_OK;
      end
      default: begin
        dv_d[0].res = c_res_q;
      end
    endcase
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int unsigned Bit = QW - 1 - k;
    logic [RW-1:0] trial;
    logic          ge_re, ge_im;
    always_comb begin
      trial = RW'(dv_q[k].den) << Bit;
      ge_re = dv_q[k].rem_re >= trial;
      ge_im = dv_q[k].rem_im >= trial;
      dv_d[k+1]          = dv_q[k];
      dv_d[k+1].rem_re   = ge_re ? dv_q[k].rem_re - trial : dv_q[k].rem_re;
      dv_d[k+1].rem_im   = ge_im ? dv_q[k].rem_im - trial : dv_q[k].rem_im;
      dv_d[k+1].q_re[Bit] = ge_re;
      dv_d[k+1].q_im[Bit] = ge_im;
    end
  end

  // Output stage.
  logic          out_v_q;
  cau_pkg::out_t out_q, out_d;
  logic [32:0]   fr, fi;
  div_t          last;

  always_comb begin
    last  = dv_q[QW];
    fr    = cau_pkg::sat_mag(last.neg_re,
                             last.ovf_re ? '1 : {{(64-QW){1'b0}}, last.q_re});
    fi    = cau_pkg::sat_mag(last.neg_im,
                             last.ovf_im ? '1 : {{(64-QW){1'b0}}, last.q_im});
    out_d = last.res;
    if (last.is_div && !last.div0) begin
      out_d.c_real = fr[31:0];
      out_d.c_imag = fi[31:0];
      out_d.status = (fr[32] || fi[32]) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
    end
  end

  assign valid_o = out_v_q;
  assign res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i <= QW; i++) dv_v_q[i] <= 1'b0;
    end else if (adv) begin
      a_v_q     <= item_valid_i;
      b_v_q     <= a_v_q;
      c_v_q     <= b_v_q;
      dv_v_q[0] <= c_v_q;
      for (int i = 0; i < QW; i++) dv_v_q[i+1] <= dv_v_q[i];
      out_v_q   <= dv_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_cls_q    <= item_i.cls;
      a_rr_q     <= a_rr_d;
      a_ii_q     <= a_ii_d;
      a_ri_q     <= a_ri_d;
      a_ir_q     <= a_ir_d;
      a_sqr_q    <= sqr_full[62:0];
      a_sqi_q    <= sqi_full[62:0];
      a_res_q    <= a_res_d;
      b_cls_q    <= a_cls_q;
      b_sre_q    <= b_sre_d;
      b_sim_q    <= b_sim_d;
      b_den_q    <= DenW'(a_sqr_q) + DenW'(a_sqi_q);
      b_res_q    <= a_res_q;
      c_cls_q    <= b_cls_q;
      c_neg_re_q <= b_sre_q[64];
      c_neg_im_q <= b_sim_q[64];
      c_mag_re_q <= b_sre_q[64] ? 64'(-b_sre_q) : 64'(b_sre_q);
      c_mag_im_q <= b_sim_q[64] ? 64'(-b_sim_q) : 64'(b_sim_q);
      c_den_q    <= b_den_q;
      c_res_q    <= b_res_q;
      for (int i = 0; i <= QW; i++) dv_q[i] <= dv_d[i];
      out_q      <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.status == cau_pkg::ST_DIV0) |-> (out_q.c_real == '0 && out_q.c_imag == '0))
    else $error("divide by zero result carries nonzero components");

  a_equal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.is_equal) |-> (out_q.status == cau_pkg::ST_OK && out_q.c_real == '0))
    else $error("equality result carries status or components");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (item_valid_i && adv))
    else $error("queue popped without an item or while the pipeline is held");
`endif

endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Complex add, subtract, multiply, divide, negate, conjugate and compare.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle while in_stall_o is low and returns one
// result per item, in order. The restoring divider resolves one quotient bit
// per stage over 33 stages; every operation passes through the same pipeline
// so results keep their order. A front register and a short queue decouple
// input acceptance from the datapath, and the datapath holds as a whole while
// the output is stalled. The comparison tolerance lives at byte address 0 of
// the register port.
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS   = cau_pkg::FracBitsDefault,
  parameter int unsigned QUEUE_DEPTH = cau_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cau_pkg::out_t out_data_o,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output logic [31:0]   prdata_o,
  output logic          pready_o
);

  logic [30:0]    tol_q, tol_d;
  logic           push, full, empty, pop;
  cau_pkg::item_t f_item, q_item;
  logic           sel_tol;

  assign pready_o = 1'b1;
  assign sel_tol  = (paddr_i[2] == cau_pkg::REG_EQUAL_TOL[0]);
  assign prdata_o = sel_tol ? {1'b0, tol_q} : '0;

  always_comb begin
    tol_d = tol_q;
    if (psel_i && penable_i && pwrite_i && sel_tol) tol_d = pwdata_i[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 31'd65;
    end else begin
      tol_q <= tol_d;
    end
  end

  cau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .item_o     (f_item),
    .full_i     (full)
  );

  cau_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_item),
    .empty_o (empty)
  );

  cau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tol_i        (tol_q),
    .item_valid_i (!empty),
    .item_i       (q_item),
    .item_pop_o   (pop),
    .valid_o      (out_valid_o),
    .res_o        (out_data_o),
    .stall_i      (out_stall_i)
  );

endmodule
